// ===== hdl/trd_pkg.sv =====
package trd_pkg;

	localparam int CRD_W = 16;
	localparam int SUM_W = 17;
	localparam int PRD_W = 34;
	localparam int AREA_W = 36;
	localparam int ZW = 16;
	localparam int NUM_W = 54;
	localparam int DEN_W = 36;

	typedef enum logic [1:0] {
		CMD_SETUP = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_FB_WIDTH    = 2'd0,
		CFG_FB_HEIGHT   = 2'd1,
		CFG_DEPTH_MODE  = 2'd2,
		CFG_CLEAR_DEPTH = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [CRD_W-1:0]  vertex0_x;
		logic signed [CRD_W-1:0]  vertex0_y;
		logic [ZW-1:0]            vertex0_z;
		logic signed [CRD_W-1:0]  vertex1_x;
		logic signed [CRD_W-1:0]  vertex1_y;
		logic [ZW-1:0]            vertex1_z;
		logic signed [CRD_W-1:0]  vertex2_x;
		logic signed [CRD_W-1:0]  vertex2_y;
		logic [ZW-1:0]            vertex2_z;
		logic [31:0]              tri_color;
	} trd_req_t;

	typedef struct packed {
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [31:0] pixel_color;
		logic        write_enable;
		logic        done_res;
	} trd_rsp_t;

	function automatic logic signed [CRD_W-1:0] min3(input logic signed [CRD_W-1:0] a,
		input logic signed [CRD_W-1:0] b, input logic signed [CRD_W-1:0] c);
		logic signed [CRD_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [CRD_W-1:0] max3(input logic signed [CRD_W-1:0] a,
		input logic signed [CRD_W-1:0] b, input logic signed [CRD_W-1:0] c);
		logic signed [CRD_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

// ===== hdl/trd_if.sv =====
interface trd_req_if;
	logic              valid;
	logic              ready;
	trd_pkg::trd_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trd_rsp_if;
	logic              valid;
	logic              ready;
	trd_pkg::trd_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/trd_divider.sv =====
module trd_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [trd_pkg::NUM_W-1:0]  num,
	input  logic [trd_pkg::DEN_W-1:0]  den,
	output logic                       busy,
	output logic                       done,
	output logic [trd_pkg::NUM_W-1:0]  quo
);
	import trd_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fit;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign fit = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], fit};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;

endmodule

// ===== hdl/trd_depth_store.sv =====
module trd_depth_store #(
	parameter int DEPTH = 65536,
	parameter int DW = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/triangle_raster_depth_test.sv =====
// Triangle rasteriser with depth test.
// Requests arrive on req (valid/ready); pixel records leave on rsp.
// cmd setup loads a triangle and computes its edge area over three
// products of the shared multiplier. cmd clear writes one depth entry if
// its coordinates lie in the store. cmd step yields one record: a done
// record for an idle block, the edge products for a pixel outside the
// triangle, and for an inside pixel the edge products, three weighted
// depth products, a 54-bit restoring divider, then a depth read and, if
// the depth test passes, a write on the depth store.
// Configuration is written on cfg_we/cfg_index/cfg_data while idle, a rule
// for the user that the block does not enforce. Reset clears the control
// state and the configuration to its defaults; the depth store is not
// cleared and must be written by clear commands before a pixel reads it.
// A stalled receiver holds the record in the output register; the block
// still accepts requests; a further step is computed, but its record
// waits in S_OUT, blocking new requests, until the output register frees.
module triangle_raster_depth_test #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int DEPTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  trd_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]       cfg_data,
	trd_req_if.sink           req,
	trd_rsp_if.source         rsp
);
	import trd_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_AREA, S_EDGE, S_TEST, S_WGT, S_DIV, S_CMP, S_OUT
	} state_t;

	state_t                  state_q;
	logic [8:0]              fbw_q, fbh_q;
	logic                    mode_q;
	logic [15:0]             clr_q;
	logic signed [CRD_W-1:0] vx_q [3];
	logic signed [CRD_W-1:0] vy_q [3];
	logic [ZW-1:0]           vz_q [3];
	logic [31:0]             color_q;
	logic [XW-1:0]           xlo_q, xhi_q, scan_x_q;
	logic [YW-1:0]           ylo_q, yhi_q, scan_y_q;
	logic                    ok_q, active_q;
	logic signed [AREA_W-1:0] area_q, acc_q;
	logic signed [AREA_W-1:0] e_q [3];
	logic [NUM_W-1:0]        num_q;
	logic [1:0]              t_q, k_q;
	logic                    div_start_q;
	logic [7:0]              pend_x_q, pend_y_q;
	logic                    pend_we_q, pend_done_q;
	logic                    rsp_valid_q;
	trd_rsp_t                rsp_q;

	logic accept;
	assign accept = req.valid && req.ready;
	assign req.ready = state_q == S_IDLE;

	// bounding box clamp
	logic [12:0]             w_eff, h_eff;
	logic signed [SUM_W-1:0] wm1, hm1, xlo_c, xhi_c, ylo_c, yhi_c;
	logic signed [CRD_W-1:0] xmin, xmax, ymin, ymax;
	logic                    box_ok;

	always_comb begin
		w_eff = (fbw_q == '0) ? 13'd1 : (13'(fbw_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(fbw_q);
		h_eff = (fbh_q == '0) ? 13'd1 : (13'(fbh_q) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(fbh_q);
		wm1 = $signed({4'b0, w_eff}) - 17'sd1;
		hm1 = $signed({4'b0, h_eff}) - 17'sd1;
		xmin = min3(req.data.vertex0_x, req.data.vertex1_x, req.data.vertex2_x);
		xmax = max3(req.data.vertex0_x, req.data.vertex1_x, req.data.vertex2_x);
		ymin = min3(req.data.vertex0_y, req.data.vertex1_y, req.data.vertex2_y);
		ymax = max3(req.data.vertex0_y, req.data.vertex1_y, req.data.vertex2_y);
		xlo_c = xmin[CRD_W-1] ? '0 : SUM_W'(xmin);
		ylo_c = ymin[CRD_W-1] ? '0 : SUM_W'(ymin);
		xhi_c = (SUM_W'(xmax) > wm1) ? wm1 : SUM_W'(xmax);
		yhi_c = (SUM_W'(ymax) > hm1) ? hm1 : SUM_W'(ymax);
		box_ok = (xlo_c < xhi_c) && (ylo_c < yhi_c);
	end

	// shared edge multiplier
	logic [1:0]              ida, idb, idc, idp, idq;
	logic signed [CRD_W-1:0] px_s, py_s, qx_s, qy_s, pix_x, pix_y;
	logic signed [SUM_W-1:0] dy, sx;
	logic signed [PRD_W-1:0] prod;
	logic signed [AREA_W-1:0] acc_d;

	assign pix_x = $signed(CRD_W'(scan_x_q));
	assign pix_y = $signed(CRD_W'(scan_y_q));

	function automatic logic signed [CRD_W-1:0] sel_pt(input logic [1:0] id,
		input logic signed [CRD_W-1:0] v0, input logic signed [CRD_W-1:0] v1,
		input logic signed [CRD_W-1:0] v2, input logic signed [CRD_W-1:0] p);
		logic signed [CRD_W-1:0] r;
		case (id)
			2'd0: r = v0;
			2'd1: r = v1;
			2'd2: r = v2;
			default: r = p;
		endcase
		return r;
	endfunction

	always_comb begin
		unique case (k_q)
			2'd0: begin ida = 2'd3; idb = 2'd1; idc = 2'd2; end
			2'd1: begin ida = 2'd3; idb = 2'd2; idc = 2'd0; end
			2'd2: begin ida = 2'd3; idb = 2'd0; idc = 2'd1; end
			default: begin ida = 2'd0; idb = 2'd1; idc = 2'd2; end
		endcase
		case (t_q)
			2'd0: begin idp = ida; idq = idc; end
			2'd1: begin idp = idc; idq = idb; end
			default: begin idp = idb; idq = ida; end
		endcase
		px_s = sel_pt(idp, vx_q[0], vx_q[1], vx_q[2], pix_x);
		py_s = sel_pt(idp, vy_q[0], vy_q[1], vy_q[2], pix_y);
		qx_s = sel_pt(idq, vx_q[0], vx_q[1], vx_q[2], pix_x);
		qy_s = sel_pt(idq, vy_q[0], vy_q[1], vy_q[2], pix_y);
		dy = SUM_W'(py_s) - SUM_W'(qy_s);
		sx = SUM_W'(px_s) + SUM_W'(qx_s);
		prod = dy * sx;
		acc_d = acc_q + AREA_W'(prod);
	end

	// weighted depth
	logic signed [AREA_W-1:0] e_sel;
	logic [DEN_W-1:0]        e_mag, den;
	logic [ZW-1:0]           z_sel;
	logic [DEN_W+ZW-1:0]     wprod;

	always_comb begin
		case (k_q)
			2'd0: begin e_sel = e_q[0]; z_sel = vz_q[0]; end
			2'd1: begin e_sel = e_q[1]; z_sel = vz_q[1]; end
			default: begin e_sel = e_q[2]; z_sel = vz_q[2]; end
		endcase
		e_mag = e_sel[AREA_W-1] ? DEN_W'(-e_sel) : DEN_W'(e_sel);
		den = area_q[AREA_W-1] ? DEN_W'(-area_q) : DEN_W'(area_q);
		wprod = e_mag * z_sel;
	end

	logic tri_hit;
	assign tri_hit = area_q > 0 ?
		(e_q[0] >= 0 && e_q[1] >= 0 && e_q[2] >= 0) :
		(e_q[0] <= 0 && e_q[1] <= 0 && e_q[2] <= 0);

	// scan advance
	logic [XW:0]   nx;
	logic [YW:0]   ny;
	logic [XW-1:0] nsx;
	logic [YW-1:0] nsy;
	logic          fin;

	always_comb begin
		ny = {1'b0, scan_y_q} + 1'b1;
		nx = {1'b0, scan_x_q} + 1'b1;
		fin = 1'b0;
		nsx = scan_x_q;
		nsy = ny[YW-1:0];
		if (ny >= {1'b0, yhi_q}) begin
			nsy = ylo_q;
			nsx = nx[XW-1:0];
			fin = nx >= {1'b0, xhi_q};
		end
	end

	// divider and depth store
	logic                  div_busy, div_done;
	logic [NUM_W-1:0]      quo;
	logic [DEPTH_BITS-1:0] old_depth, new_depth;
	logic                  pass;
	logic                  clr_hit, mem_we, mem_re;
	logic [AW-1:0]         clr_addr, pix_addr, mem_waddr;
	logic [DEPTH_BITS-1:0] mem_wdata;
	logic [CRD_W-1:0]      cx_u, cy_u;

	trd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	assign new_depth = quo[DEPTH_BITS-1:0];
	assign pass = mode_q ? (new_depth < old_depth) : (new_depth > old_depth);
	assign cx_u = req.data.vertex0_x;
	assign cy_u = req.data.vertex0_y;
	assign clr_hit = accept && req.data.cmd == CMD_CLEAR &&
		cx_u < CRD_W'(MAX_WIDTH) && cy_u < CRD_W'(MAX_HEIGHT);
	assign clr_addr = AW'(cy_u) * AW'(MAX_WIDTH) + AW'(cx_u);
	assign pix_addr = AW'(scan_y_q) * AW'(MAX_WIDTH) + AW'(scan_x_q);
	assign mem_re = state_q == S_DIV && div_done;
	assign mem_we = clr_hit || (state_q == S_CMP && pass);
	assign mem_waddr = clr_hit ? clr_addr : pix_addr;
	assign mem_wdata = clr_hit ? DEPTH_BITS'(clr_q) : new_depth;

	trd_depth_store #(.DEPTH(DEPTH), .DW(DEPTH_BITS)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (pix_addr),
		.rdata (old_depth)
	);

	logic [15:0] sx16, sy16;
	assign sx16 = 16'(scan_x_q);
	assign sy16 = 16'(scan_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fbw_q <= 9'd256;
			fbh_q <= 9'd256;
			mode_q <= 1'b0;
			clr_q <= '0;
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				vz_q[i] <= '0;
				e_q[i] <= '0;
			end
			color_q <= '0;
			xlo_q <= '0;
			xhi_q <= '0;
			ylo_q <= '0;
			yhi_q <= '0;
			scan_x_q <= '0;
			scan_y_q <= '0;
			ok_q <= 1'b0;
			active_q <= 1'b0;
			area_q <= '0;
			acc_q <= '0;
			num_q <= '0;
			t_q <= '0;
			k_q <= '0;
			div_start_q <= 1'b0;
			pend_x_q <= '0;
			pend_y_q <= '0;
			pend_we_q <= 1'b0;
			pend_done_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FB_WIDTH:    fbw_q <= cfg_data[8:0];
					CFG_FB_HEIGHT:   fbh_q <= cfg_data[8:0];
					CFG_DEPTH_MODE:  mode_q <= cfg_data[0];
					CFG_CLEAR_DEPTH: clr_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.data.cmd)
							CMD_SETUP: begin
								vx_q[0] <= req.data.vertex0_x;
								vy_q[0] <= req.data.vertex0_y;
								vz_q[0] <= req.data.vertex0_z;
								vx_q[1] <= req.data.vertex1_x;
								vy_q[1] <= req.data.vertex1_y;
								vz_q[1] <= req.data.vertex1_z;
								vx_q[2] <= req.data.vertex2_x;
								vy_q[2] <= req.data.vertex2_y;
								vz_q[2] <= req.data.vertex2_z;
								color_q <= req.data.tri_color;
								xlo_q <= xlo_c[XW-1:0];
								xhi_q <= xhi_c[XW-1:0];
								ylo_q <= ylo_c[YW-1:0];
								yhi_q <= yhi_c[YW-1:0];
								scan_x_q <= xlo_c[XW-1:0];
								scan_y_q <= ylo_c[YW-1:0];
								ok_q <= box_ok;
								active_q <= 1'b0;
								acc_q <= '0;
								t_q <= '0;
								k_q <= 2'd3;
								state_q <= S_AREA;
							end
							CMD_STEP: begin
								if (active_q) begin
									acc_q <= '0;
									t_q <= '0;
									k_q <= '0;
									state_q <= S_EDGE;
								end else begin
									pend_x_q <= '0;
									pend_y_q <= '0;
									pend_we_q <= 1'b0;
									pend_done_q <= 1'b1;
									state_q <= S_OUT;
								end
							end
							default: ;
						endcase
					end
				end
				S_AREA: begin
					acc_q <= acc_d;
					t_q <= t_q + 1'b1;
					if (t_q == 2'd2) begin
						area_q <= acc_d;
						active_q <= ok_q && acc_d != 0;
						state_q <= S_IDLE;
					end
				end
				S_EDGE: begin
					acc_q <= acc_d;
					t_q <= t_q + 1'b1;
					if (t_q == 2'd2) begin
						e_q[k_q] <= acc_d;
						acc_q <= '0;
						t_q <= '0;
						k_q <= k_q + 1'b1;
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= S_TEST;
						end
					end
				end
				S_TEST: begin
					pend_x_q <= sx16[7:0];
					pend_y_q <= sy16[7:0];
					num_q <= '0;
					if (tri_hit) begin
						state_q <= S_WGT;
					end else begin
						pend_we_q <= 1'b0;
						pend_done_q <= fin;
						scan_x_q <= nsx;
						scan_y_q <= nsy;
						if (fin) begin
							active_q <= 1'b0;
						end
						state_q <= S_OUT;
					end
				end
				S_WGT: begin
					num_q <= num_q + NUM_W'(wprod);
					k_q <= k_q + 1'b1;
					if (k_q == 2'd2) begin
						k_q <= '0;
						div_start_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					pend_we_q <= pass;
					pend_done_q <= fin;
					scan_x_q <= nsx;
					scan_y_q <= nsy;
					if (fin) begin
						active_q <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q.pixel_x <= pend_x_q;
						rsp_q.pixel_y <= pend_y_q;
						rsp_q.pixel_color <= pend_we_q ? color_q : '0;
						rsp_q.write_enable <= pend_we_q;
						rsp_q.done_res <= pend_done_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	a_cmp_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |=> (state_q == S_OUT))
		else $error("compare did not hand over to output");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> !div_busy)
		else $error("divider started while busy");
	a_wgt_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WGT) |-> active_q)
		else $error("weighting without an active triangle");
	a_store_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clr_hit) |-> (state_q == S_CMP && $past(state_q) == S_DIV))
		else $error("depth write outside read-modify-write");

endmodule
